### hw/rtl/sdes_pkg.sv
// ----------------------------------------------------------------------------
// S-DES package
// Shared types, S-box tables and the S-DES round functions.
// ----------------------------------------------------------------------------
package sdes_pkg;

  localparam int unsigned KeyW       = 10;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned SubkeyW    = 8;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned CfgDataW   = KeyW;
  localparam int unsigned QueueDepthDef = 2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgIdxKey     = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxDecrypt = 1'd1;

  // S-boxes, indexed by {row, column}
  localparam logic [1:0] Sbox0 [16] = '{
    2'd1, 2'd0, 2'd3, 2'd2,
    2'd3, 2'd2, 2'd1, 2'd0,
    2'd0, 2'd2, 2'd1, 2'd3,
    2'd3, 2'd1, 2'd3, 2'd2
  };
  localparam logic [1:0] Sbox1 [16] = '{
    2'd0, 2'd1, 2'd2, 2'd3,
    2'd2, 2'd0, 2'd1, 2'd3,
    2'd3, 2'd0, 2'd1, 2'd0,
    2'd2, 2'd1, 2'd0, 2'd3
  };

  // Subkeys in the order the two rounds use them
  typedef struct packed {
    logic [SubkeyW-1:0] first;
    logic [SubkeyW-1:0] second;
  } round_keys_t;

  // One queue transaction between front and back
  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] data;
  } xfer_t;

  function automatic logic [ByteW-1:0] perm_ip(input logic [ByteW-1:0] v);
    return {v[6], v[2], v[5], v[7], v[4], v[0], v[3], v[1]};
  endfunction

  function automatic logic [ByteW-1:0] perm_ipi(input logic [ByteW-1:0] v);
    return {v[4], v[7], v[5], v[3], v[1], v[6], v[0], v[2]};
  endfunction

  function automatic logic [ByteW-1:0] nibble_swap(input logic [ByteW-1:0] v);
    return {v[3:0], v[7:4]};
  endfunction

  // Expand right nibble, mix in subkey, substitute, permute by P4
  function automatic logic [3:0] func_f(input logic [3:0] r,
                                        input logic [SubkeyW-1:0] sk);
    logic [7:0] t;
    logic [1:0] s0;
    logic [1:0] s1;
    t  = {r[0], r[3], r[2], r[1], r[2], r[1], r[0], r[3]} ^ sk;
    s0 = Sbox0[{t[7], t[4], t[6:5]}];
    s1 = Sbox1[{t[3], t[0], t[2:1]}];
    return {s0[0], s1[0], s1[1], s0[1]};
  endfunction

  function automatic logic [ByteW-1:0] func_fk(input logic [ByteW-1:0] v,
                                               input logic [SubkeyW-1:0] sk);
    return {v[7:4] ^ func_f(v[3:0], sk), v[3:0]};
  endfunction

  // Key schedule: P10, rotate halves by one then by two more, P8 each time
  function automatic round_keys_t key_schedule(input logic [KeyW-1:0] k,
                                               input logic decrypt);
    logic [KeyW-1:0]    p;
    logic [KeyW-1:0]    r1;
    logic [KeyW-1:0]    r3;
    logic [SubkeyW-1:0] k1;
    logic [SubkeyW-1:0] k2;
    round_keys_t        rk;
    p  = {k[7], k[5], k[8], k[3], k[6], k[0], k[9], k[1], k[2], k[4]};
    r1 = {p[8:5], p[9], p[3:0], p[4]};
    r3 = {p[6:5], p[9:7], p[1:0], p[4:2]};
    k1 = {r1[4], r1[7], r1[3], r1[6], r1[2], r1[5], r1[0], r1[1]};
    k2 = {r3[4], r3[7], r3[3], r3[6], r3[2], r3[5], r3[0], r3[1]};
    rk.first  = decrypt ? k2 : k1;
    rk.second = decrypt ? k1 : k2;
    return rk;
  endfunction

endpackage

### hw/rtl/sdes_in_if.sv
// ----------------------------------------------------------------------------
// S-DES input channel
// Valid/ready channel carrying one input byte per transaction.
// ----------------------------------------------------------------------------
interface sdes_in_if;
  logic                      valid;
  logic                      ready;
  logic [sdes_pkg::ByteW-1:0] data_in;

  modport source (output valid, output data_in, input ready);
  modport sink   (input valid, input data_in, output ready);
endinterface

### hw/rtl/sdes_out_if.sv
// ----------------------------------------------------------------------------
// S-DES output channel
// Valid/ready channel carrying one result byte per transaction.
// ----------------------------------------------------------------------------
interface sdes_out_if;
  logic                      valid;
  logic                      ready;
  logic [sdes_pkg::ByteW-1:0] data_out;

  modport source (output valid, output data_out, input ready);
  modport sink   (input valid, input data_out, output ready);
endinterface

### hw/rtl/sdes_byte_cipher_unit.sv
// ----------------------------------------------------------------------------
// S-DES byte cipher unit
// An input byte passes the front register, the queue and the output register
// before it can leave as an output transaction.
// Throughput: one byte per cycle while neither side stalls; the queue lets either side stall alone.
// Reset: key and mode clear to 0, all stages and the queue empty.
// ----------------------------------------------------------------------------
module sdes_byte_cipher_unit #(
  parameter int unsigned QueueDepth = sdes_pkg::QueueDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  sdes_in_if.sink                       in_if,
  sdes_out_if.source                    out_if,
  input  logic                          cfg_we_i,
  input  logic [sdes_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sdes_pkg::CfgDataW-1:0] cfg_wdata_i
);

  logic [sdes_pkg::KeyW-1:0] cipher_key_q;
  logic                      decrypt_mode_q;
  sdes_pkg::round_keys_t     keys;
  sdes_pkg::xfer_t           push, pop;
  logic                      push_ready, pop_ready;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cipher_key_q   <= '0;
      decrypt_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sdes_pkg::CfgIdxKey:     cipher_key_q   <= cfg_wdata_i[sdes_pkg::KeyW-1:0];
        sdes_pkg::CfgIdxDecrypt: decrypt_mode_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Derive round keys in use order
  assign keys = sdes_pkg::key_schedule(cipher_key_q, decrypt_mode_q);

  sdes_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_if        (in_if),
    .keys_i       (keys),
    .push_o       (push),
    .push_ready_i (push_ready)
  );

  sdes_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .pop_o        (pop),
    .pop_ready_i  (pop_ready)
  );

  sdes_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_i       (pop),
    .pop_ready_o (pop_ready),
    .keys_i      (keys),
    .out_if      (out_if)
  );

endmodule

### hw/rtl/sdes_front.sv
// ----------------------------------------------------------------------------
// S-DES front stage
// Accepts input bytes, applies IP, the first fk round and the nibble swap.
// ----------------------------------------------------------------------------
module sdes_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  sdes_in_if.sink               in_if,
  input  sdes_pkg::round_keys_t keys_i,
  output sdes_pkg::xfer_t       push_o,
  input  logic                  push_ready_i
);

  logic                       stage_valid_d, stage_valid_q;
  logic [sdes_pkg::ByteW-1:0] stage_data_d, stage_data_q;
  logic                       accept;

  // Take a new transaction when the stage is empty or draining
  assign in_if.ready = !stage_valid_q || push_ready_i;
  assign accept      = in_if.valid && in_if.ready;

  always_comb begin
    stage_valid_d = stage_valid_q;
    stage_data_d  = stage_data_q;
    if (accept) begin
      stage_valid_d = 1'b1;
      stage_data_d  = sdes_pkg::nibble_swap(
        sdes_pkg::func_fk(sdes_pkg::perm_ip(in_if.data_in), keys_i.first));
    end else if (push_ready_i) begin
      stage_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else begin
      stage_valid_q <= stage_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stage_data_q <= stage_data_d;
  end

  assign push_o.valid = stage_valid_q;
  assign push_o.data  = stage_data_q;

endmodule

### hw/rtl/sdes_queue.sv
// ----------------------------------------------------------------------------
// S-DES decoupling queue
// Small FIFO between the front and back stages.
// ----------------------------------------------------------------------------
module sdes_queue #(
  parameter int unsigned Depth = sdes_pkg::QueueDepthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sdes_pkg::xfer_t push_i,
  output logic            push_ready_o,
  output sdes_pkg::xfer_t pop_o,
  input  logic            pop_ready_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [sdes_pkg::ByteW-1:0] entry_q [Depth];
  logic [PtrW-1:0]            wr_ptr_d, wr_ptr_q;
  logic [PtrW-1:0]            rd_ptr_d, rd_ptr_q;
  logic [CntW-1:0]            count_d, count_q;
  logic                       do_push, do_pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign do_push      = push_i.valid && push_ready_o;
  assign pop_o.valid  = (count_q != '0);
  assign pop_o.data   = entry_q[rd_ptr_q];
  assign do_pop       = pop_o.valid && pop_ready_i;

  // Advance pointers with wrap and track occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store pushed transaction
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_i.data;
    end
  end

endmodule

### hw/rtl/sdes_back.sv
// ----------------------------------------------------------------------------
// S-DES back stage
// Applies the second fk round and IP inverse into the output register.
// ----------------------------------------------------------------------------
module sdes_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sdes_pkg::xfer_t       pop_i,
  output logic                  pop_ready_o,
  input  sdes_pkg::round_keys_t keys_i,
  sdes_out_if.source            out_if
);

  logic                       out_valid_d, out_valid_q;
  logic [sdes_pkg::ByteW-1:0] out_data_d, out_data_q;
  logic                       take;

  // Pull from the queue when the output register is free or being taken
  assign pop_ready_o = !out_valid_q || out_if.ready;
  assign take        = pop_i.valid && pop_ready_o;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (take) begin
      out_valid_d = 1'b1;
      out_data_d  = sdes_pkg::perm_ipi(sdes_pkg::func_fk(pop_i.data, keys_i.second));
    end else if (out_if.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_if.valid    = out_valid_q;
  assign out_if.data_out = out_data_q;

endmodule

### hw/rtl/sdes_checker.sv
// ----------------------------------------------------------------------------
// S-DES port checker
// Watches the unit's ports for handshake and in-flight consistency.
// ----------------------------------------------------------------------------
module sdes_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [sdes_pkg::ByteW-1:0] out_data_i
);

  logic [7:0] inflight_d, inflight_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // Track transactions accepted but not yet delivered
  always_comb begin
    inflight_d = inflight_q;
    if (in_acc && !out_acc) begin
      inflight_d = inflight_q + 8'd1;
    end else if (out_acc && !in_acc) begin
      inflight_d = inflight_q - 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output valid dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("output data changed while stalled");

  // No result without an outstanding input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> inflight_q != 8'd0)
    else $error("result presented with nothing in flight");

  // An empty unit must take input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q == 8'd0 |-> in_ready_i)
    else $error("empty unit not ready for input");

endmodule

bind sdes_byte_cipher_unit sdes_checker u_sdes_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_data_i  (out_if.data_out)
);

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// S-DES byte cipher unit testbench
// Sends bytes through the cipher under a series of key and direction settings.
// A short table of directed bytes, including the textbook S-DES vector, comes
// first. Random bytes follow. Both channels stall at random. Each output byte is
// checked against a typed-in result or a local S-DES model, key schedule included.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseCount = 12;
  localparam int unsigned PhaseBytes = 96;
  localparam int unsigned MaxWait    = 19;
  localparam int unsigned DrainWait  = 10;

  // Permutation tables, one hex digit per output bit, MSB first; entry p
  // selects input bit p counted from the MSB
  localparam logic [39:0] P10_TAB = 40'h35274A1986;
  localparam logic [39:0] P8_TAB  = 40'h637485A900;
  localparam logic [39:0] IP_TAB  = 40'h2631485700;
  localparam logic [39:0] IPI_TAB = 40'h4135728600;
  localparam logic [39:0] EP_TAB  = 40'h4123234100;
  localparam logic [39:0] P4_TAB  = 40'h2431000000;

  // S-boxes, row-major 4x4, two bits per entry, first entry at the MSB
  localparam logic [31:0] SBOX0 = {2'd1, 2'd0, 2'd3, 2'd2, 2'd3, 2'd2, 2'd1, 2'd0,
                                   2'd0, 2'd2, 2'd1, 2'd3, 2'd3, 2'd1, 2'd3, 2'd2};
  localparam logic [31:0] SBOX1 = {2'd0, 2'd1, 2'd2, 2'd3, 2'd2, 2'd0, 2'd1, 2'd3,
                                   2'd3, 2'd0, 2'd1, 2'd0, 2'd2, 2'd1, 2'd0, 2'd3};

  // One directed row: optional new setting, the byte, and a typed-in result
  typedef struct packed {
    logic                       new_cfg;
    logic [sdes_pkg::KeyW-1:0]  key;
    logic [sdes_pkg::KeyW-1:0]  mode_raw;
    logic [sdes_pkg::ByteW-1:0] data;
    logic                       known;
    logic [sdes_pkg::ByteW-1:0] want;
  } dir_row_t;

  localparam int unsigned DirRows = 19;
  localparam dir_row_t DIRECTED [DirRows] = '{
    // reset setting: key 0, encrypt
    '{1'b0, 10'h000, 10'h000, 8'h00, 1'b0, 8'h00},
    '{1'b0, 10'h000, 10'h000, 8'hFF, 1'b0, 8'h00},
    '{1'b0, 10'h000, 10'h000, 8'h55, 1'b0, 8'h00},
    '{1'b0, 10'h000, 10'h000, 8'hAA, 1'b0, 8'h00},
    // textbook vector: key 1010000010, plaintext 10010111
    '{1'b1, 10'h282, 10'h000, 8'h97, 1'b1, 8'h38},
    '{1'b0, 10'h282, 10'h000, 8'h00, 1'b0, 8'h00},
    '{1'b0, 10'h282, 10'h000, 8'hFF, 1'b0, 8'h00},
    // decrypt written with all upper bits set; they must be dropped
    '{1'b1, 10'h282, 10'h3FF, 8'h38, 1'b1, 8'h97},
    '{1'b0, 10'h282, 10'h3FF, 8'h00, 1'b0, 8'h00},
    // encrypt written with upper bits set, all-ones key
    '{1'b1, 10'h3FF, 10'h3FE, 8'h00, 1'b0, 8'h00},
    '{1'b0, 10'h3FF, 10'h3FE, 8'hFF, 1'b0, 8'h00},
    '{1'b0, 10'h3FF, 10'h3FE, 8'h80, 1'b0, 8'h00},
    '{1'b0, 10'h3FF, 10'h3FE, 8'h01, 1'b0, 8'h00},
    '{1'b1, 10'h3FF, 10'h001, 8'h00, 1'b0, 8'h00},
    '{1'b0, 10'h3FF, 10'h001, 8'hFF, 1'b0, 8'h00},
    '{1'b1, 10'h000, 10'h001, 8'h00, 1'b0, 8'h00},
    '{1'b0, 10'h000, 10'h001, 8'hFF, 1'b0, 8'h00},
    '{1'b1, 10'h201, 10'h000, 8'h7F, 1'b0, 8'h00},
    '{1'b0, 10'h201, 10'h000, 8'hFE, 1'b0, 8'h00}
  };

  logic clk_i;
  logic rst_ni;
  logic                          cfg_we_i;
  logic [sdes_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [sdes_pkg::CfgDataW-1:0] cfg_wdata_i;

  sdes_in_if  in_ch ();
  sdes_out_if out_ch ();

  sdes_byte_cipher_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Local copy of the configuration and the bytes still owed by the block
  logic [sdes_pkg::KeyW-1:0]  cur_key;
  logic                       cur_decrypt;
  logic [sdes_pkg::ByteW-1:0] pending_bytes [$];

  int unsigned mismatches;
  int unsigned bytes_sent;
  int unsigned bytes_checked;
  int unsigned settings_used;
  int unsigned cycle_cnt;
  int          tx_quiet;
  int          rx_quiet;

  // Output bit i takes input bit tab[i], counted 1..in_w from the MSB
  function automatic logic [9:0] shuffle_bits(logic [9:0] v, int in_w,
                                              logic [39:0] tab, int n);
    logic [9:0] r;
    int         pos;
    r = '0;
    for (int i = 0; i < n; i++) begin
      pos = int'(tab[39-4*i -: 4]);
      r   = {r[8:0], v[in_w-pos]};
    end
    return r;
  endfunction

  function automatic logic [4:0] rotl5(logic [4:0] v, int k);
    for (int i = 0; i < k; i++) begin
      v = {v[3:0], v[4]};
    end
    return v;
  endfunction

  // Row from the outer bits, column from the inner two
  function automatic logic [1:0] sbox_pick(logic [31:0] box, logic [3:0] nib);
    int idx;
    idx = int'({nib[3], nib[0], nib[2:1]});
    return box[31-2*idx -: 2];
  endfunction

  function automatic logic [7:0] feistel_round(logic [7:0] v, logic [7:0] sk);
    logic [9:0] wide;
    logic [7:0] mixed;
    logic [3:0] sboxed;
    wide   = shuffle_bits({6'd0, v[3:0]}, 4, EP_TAB, 8);
    mixed  = wide[7:0] ^ sk;
    sboxed = {sbox_pick(SBOX0, mixed[7:4]), sbox_pick(SBOX1, mixed[3:0])};
    wide   = shuffle_bits({6'd0, sboxed}, 4, P4_TAB, 4);
    return {v[7:4] ^ wide[3:0], v[3:0]};
  endfunction

  // Full S-DES on one byte with the given key and direction
  function automatic logic [7:0] sdes_cipher_byte(logic [7:0] d, logic [9:0] key,
                                                  logic decrypt);
    logic [9:0] wide;
    logic [4:0] hl;
    logic [4:0] hr;
    logic [7:0] k1;
    logic [7:0] k2;
    logic [7:0] v;
    wide = shuffle_bits(key, 10, P10_TAB, 10);
    hl   = rotl5(wide[9:5], 1);
    hr   = rotl5(wide[4:0], 1);
    wide = shuffle_bits({hl, hr}, 10, P8_TAB, 8);
    k1   = wide[7:0];
    hl   = rotl5(hl, 2);
    hr   = rotl5(hr, 2);
    wide = shuffle_bits({hl, hr}, 10, P8_TAB, 8);
    k2   = wide[7:0];
    wide = shuffle_bits({2'd0, d}, 8, IP_TAB, 8);
    v    = feistel_round(wide[7:0], decrypt ? k2 : k1);
    v    = {v[3:0], v[7:4]};
    v    = feistel_round(v, decrypt ? k1 : k2);
    wide = shuffle_bits({2'd0, v}, 8, IPI_TAB, 8);
    return wide[7:0];
  endfunction

  // Draw a random wait, with occasional stretches of no waits
  task automatic pick_wait(inout int quiet, output int gap);
    if (quiet > 0) begin
      quiet--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, MaxWait);
      if ($urandom_range(0, 31) == 0) begin
        quiet = $urandom_range(8, 40);
      end
    end
  endtask

  // Offer one byte and record its expected result when the transaction lands
  task automatic send_byte(logic [sdes_pkg::ByteW-1:0] d, logic known,
                           logic [sdes_pkg::ByteW-1:0] want);
    int gap;
    pick_wait(tx_quiet, gap);
    @(negedge clk_i);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.data_in <= d;
    do @(posedge clk_i); while (!in_ch.ready);
    pending_bytes.push_back(known ? want : sdes_cipher_byte(d, cur_key, cur_decrypt));
    bytes_sent++;
  endtask

  // Drop valid and wait until every owed byte has come out
  task automatic drain_block();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [sdes_pkg::CfgIdxW-1:0] idx,
                           logic [sdes_pkg::CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == sdes_pkg::CfgIdxKey) begin
      cur_key = value[sdes_pkg::KeyW-1:0];
    end else begin
      cur_decrypt = value[0];
    end
  endtask

  task automatic apply_setting(logic [sdes_pkg::KeyW-1:0] key,
                               logic [sdes_pkg::KeyW-1:0] mode_raw);
    drain_block();
    write_reg(sdes_pkg::CfgIdxKey, key);
    write_reg(sdes_pkg::CfgIdxDecrypt, mode_raw);
    settings_used++;
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Bound the run
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("[sdes_byte_cipher_unit] ERROR");
    $finish;
  end

  // Result side: stall a random number of cycles before each transaction
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    rx_quiet     = 0;
    @(posedge rst_ni);
    forever begin
      pick_wait(rx_quiet, stall);
      @(negedge clk_i);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
    end
  end

  // Compare each output transaction with the oldest owed byte
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_bytes.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected data_out, expected none, got %02h",
                 $time, out_ch.data_out);
      end else begin
        if (out_ch.data_out !== pending_bytes[0]) begin
          mismatches++;
          $display("%0t: data_out mismatch, expected %02h, got %02h",
                   $time, pending_bytes[0], out_ch.data_out);
        end
        void'(pending_bytes.pop_front());
        bytes_checked++;
      end
    end
  end

  // Stimulus
  initial begin
    logic [sdes_pkg::KeyW-1:0] key;
    logic [sdes_pkg::KeyW-1:0] mode_raw;
    rst_ni        = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.data_in = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = sdes_pkg::CfgIdxKey;
    cfg_wdata_i   = '0;
    cur_key       = '0;
    cur_decrypt   = 1'b0;
    mismatches    = 0;
    bytes_sent    = 0;
    bytes_checked = 0;
    settings_used = 1;
    tx_quiet      = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table
    for (int r = 0; r < DirRows; r++) begin
      if (DIRECTED[r].new_cfg) begin
        apply_setting(DIRECTED[r].key, DIRECTED[r].mode_raw);
      end
      send_byte(DIRECTED[r].data, DIRECTED[r].known, DIRECTED[r].want);
    end

    // Random phases: extreme keys first, direction alternates, junk upper mode bits
    for (int p = 0; p < PhaseCount; p++) begin
      if (p == 0) begin
        key = '0;
      end else if (p == 1) begin
        key = '1;
      end else begin
        key = 10'($urandom_range(0, 1023));
      end
      mode_raw = {9'($urandom_range(0, 511)), p[0]};
      apply_setting(key, mode_raw);
      for (int i = 0; i < PhaseBytes; i++) begin
        send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
      end
    end

    drain_block();
    repeat (DrainWait) @(posedge clk_i);
    $display("Covered %0d bytes (%0d checked) over %0d key and direction settings,",
             bytes_sent, bytes_checked, settings_used);
    $display("with random stalls of 0 to %0d cycles on both channels.", MaxWait);
    if (mismatches == 0) begin
      $display("[sdes_byte_cipher_unit] OK");
    end else begin
      $display("[sdes_byte_cipher_unit] ERROR");
    end
    $finish;
  end

endmodule
